>>> rtl/core/assert_macros.svh
// Assertion macros shared by the LZSS ring decompressor RTL.
// Depends on nothing; users must have clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define LZSSR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Condition that must never be true outside reset.
`define LZSSR_NEVER(lbl, cond, msg) \
	`LZSSR_ASSERT(lbl, !(cond), msg)

`endif

>>> rtl/core/lzssr_pkg.sv
// Shared types and constants for the LZSS ring decompressor.
// Used by lzssr_ctrl, lzssr_dp and lzss_ring_decompressor; depends on nothing.
package lzssr_pkg;

	localparam int RING_DEPTH = 4096;
	localparam int RING_AW    = $clog2(RING_DEPTH);

	localparam logic [RING_AW-1:0] START_POS  = RING_AW'(12'hFEE);
	localparam logic [7:0]         FILL_BYTE  = 8'h20;
	localparam logic [2:0]         MAX_PREFIX = 3'd4;
	localparam logic [3:0]         NEED_FLAG  = 4'd8;
	// Length nibble plus this gives the count of bytes still to copy after the first.
	localparam logic [4:0]         LEN_BIAS_M1 = 5'd2;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       start_of_file;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COPY_RD,
		ST_COPY_WR
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic restart;
		logic prefix_emit;
		logic flag_load;
		logic low_hold;
		logic copy_start;
		logic lit_emit;
		logic copy_read;
		logic copy_write;
	} cmd_t;

	// Status from the datapath, already adjusted for a start-of-file mark on the
	// item at the input.
	typedef struct packed {
		logic sof;
		logic prefix_active;
		logic need_flag;
		logic awaiting;
		logic flag_set;
		logic out_free;
		logic copy_last;
	} sts_t;

endpackage

>>> rtl/core/lzssr_ctrl.sv
// Controller state machine of the LZSS ring decompressor.
// Depends on lzssr_pkg; drives the command struct of lzssr_dp.
module lzssr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  lzssr_pkg::sts_t   sts,
	output lzssr_pkg::cmd_t   cmd
);

	lzssr_pkg::state_t state_q;
	lzssr_pkg::state_t state_next;
	logic              fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lzssr_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	assign fire = in_valid && in_ready;

	always_comb begin
		state_next = state_q;
		case (state_q)
			lzssr_pkg::ST_IDLE: begin
				if (cmd.copy_start) begin
					state_next = lzssr_pkg::ST_COPY_RD;
				end
			end
			lzssr_pkg::ST_COPY_RD: begin
				state_next = lzssr_pkg::ST_COPY_WR;
			end
			lzssr_pkg::ST_COPY_WR: begin
				if (sts.out_free) begin
					state_next = sts.copy_last ? lzssr_pkg::ST_IDLE : lzssr_pkg::ST_COPY_RD;
				end
			end
			default: begin
				state_next = lzssr_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			lzssr_pkg::ST_IDLE: begin
				in_ready    = sts.out_free;
				cmd.restart = fire && sts.sof;
				if (fire) begin
					if (sts.prefix_active) begin
						cmd.prefix_emit = 1'b1;
					end else if (sts.need_flag) begin
						cmd.flag_load = 1'b1;
					end else if (sts.awaiting) begin
						cmd.copy_start = 1'b1;
					end else if (sts.flag_set) begin
						cmd.lit_emit = 1'b1;
					end else begin
						cmd.low_hold = 1'b1;
					end
				end
			end
			lzssr_pkg::ST_COPY_RD: begin
				cmd.copy_read = 1'b1;
			end
			lzssr_pkg::ST_COPY_WR: begin
				cmd.copy_write = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

>>> rtl/core/lzssr_dp.sv
// Datapath of the LZSS ring decompressor: decoder registers, history ring,
// output register. Depends on lzssr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lzssr_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [2:0]           cfg_wr_data,
	input  lzssr_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output lzssr_pkg::out_item_t out_data,
	input  lzssr_pkg::cmd_t      cmd,
	output lzssr_pkg::sts_t      sts
);

	localparam int AW = lzssr_pkg::RING_AW;

	logic [2:0]    raw_prefix_len_q;
	logic [2:0]    prefix_q;
	logic [7:0]    flag_q;
	logic [3:0]    bit_index_q;
	logic          awaiting_q;
	logic [7:0]    held_q;
	logic [AW-1:0] src_q;
	logic [4:0]    cnt_q;
	logic [AW-1:0] wp_q;
	logic [AW:0]   fill_q;
	logic [7:0]    rd_data_q;
	logic          rd_hit_q;
	logic          out_valid_q;
	lzssr_pkg::out_item_t out_q;

	logic [7:0]    ring [lzssr_pkg::RING_DEPTH];

	logic [2:0]    prefix_load;
	logic [2:0]    prefix_base;
	logic          ring_we;
	logic [7:0]    copy_byte;
	logic [7:0]    ring_wdata;
	logic [AW-1:0] src_rel;
	logic          src_hit;
	logic          inc_bit;

	// Prefix lengths above four act as four.
	assign prefix_load = (raw_prefix_len_q > lzssr_pkg::MAX_PREFIX) ?
		lzssr_pkg::MAX_PREFIX : raw_prefix_len_q;
	assign prefix_base = in_data.start_of_file ? prefix_load : prefix_q;

	assign sts.sof           = in_data.start_of_file;
	assign sts.prefix_active = (prefix_base != 3'd0);
	assign sts.need_flag     = in_data.start_of_file || (bit_index_q == lzssr_pkg::NEED_FLAG);
	assign sts.awaiting      = !in_data.start_of_file && awaiting_q;
	assign sts.flag_set      = flag_q[bit_index_q[2:0]];
	assign sts.out_free      = !out_valid_q || out_ready;
	assign sts.copy_last     = (cnt_q == 5'd0);

	assign ring_we    = cmd.lit_emit || cmd.copy_write;
	assign copy_byte  = rd_hit_q ? rd_data_q : lzssr_pkg::FILL_BYTE;
	assign ring_wdata = cmd.lit_emit ? in_data.in_byte : copy_byte;
	assign inc_bit    = cmd.lit_emit || (cmd.copy_write && sts.copy_last);

	// The ring is written in order from the start position, so an entry holds
	// file data exactly when it lies within the first fill_q entries from there.
	assign src_rel = src_q - lzssr_pkg::START_POS;
	assign src_hit = ({1'b0, src_rel} < fill_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_prefix_len_q <= 3'd0;
			prefix_q         <= 3'd0;
			bit_index_q      <= lzssr_pkg::NEED_FLAG;
			awaiting_q       <= 1'b0;
			wp_q             <= lzssr_pkg::START_POS;
			fill_q           <= '0;
			out_valid_q      <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				raw_prefix_len_q <= cfg_wr_data;
			end
			if (cmd.prefix_emit) begin
				prefix_q <= prefix_base - 3'd1;
			end else if (cmd.restart) begin
				prefix_q <= prefix_load;
			end
			if (cmd.flag_load) begin
				bit_index_q <= 4'd0;
			end else if (cmd.restart) begin
				bit_index_q <= lzssr_pkg::NEED_FLAG;
			end else if (inc_bit) begin
				bit_index_q <= bit_index_q + 4'd1;
			end
			if (cmd.restart || cmd.copy_start) begin
				awaiting_q <= 1'b0;
			end else if (cmd.low_hold) begin
				awaiting_q <= 1'b1;
			end
			if (cmd.restart) begin
				wp_q   <= lzssr_pkg::START_POS;
				fill_q <= '0;
			end else if (ring_we) begin
				wp_q <= wp_q + AW'(1);
				if (fill_q != (AW+1)'(lzssr_pkg::RING_DEPTH)) begin
					fill_q <= fill_q + (AW+1)'(1);
				end
			end
			if (cmd.prefix_emit || cmd.lit_emit || cmd.copy_write) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.flag_load) begin
			flag_q <= in_data.in_byte;
		end
		if (cmd.low_hold) begin
			held_q <= in_data.in_byte;
		end
		if (cmd.copy_start) begin
			src_q <= {in_data.in_byte[3:0], held_q};
			cnt_q <= {1'b0, in_data.in_byte[7:4]} + lzssr_pkg::LEN_BIAS_M1;
		end else begin
			if (cmd.copy_read) begin
				src_q <= src_q + AW'(1);
			end
			if (cmd.copy_write) begin
				cnt_q <= cnt_q - 5'd1;
			end
		end
		if (cmd.copy_read) begin
			rd_hit_q <= src_hit;
		end
		if (cmd.prefix_emit || cmd.lit_emit) begin
			out_q.out_byte    <= in_data.in_byte;
			out_q.last_of_run <= 1'b1;
		end else if (cmd.copy_write) begin
			out_q.out_byte    <= copy_byte;
			out_q.last_of_run <= sts.copy_last;
		end
	end

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring[wp_q] <= ring_wdata;
		end
		if (cmd.copy_read) begin
			rd_data_q <= ring[src_q];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`LZSSR_NEVER(a_fill_bounded, fill_q > (AW+1)'(lzssr_pkg::RING_DEPTH), "ring fill count overran")
	`LZSSR_NEVER(a_bit_index_range, bit_index_q > lzssr_pkg::NEED_FLAG, "flag bit index out of range")
	`LZSSR_ASSERT(a_copy_shows, cmd.copy_write |=> out_valid_q, "copied byte not presented")
	`LZSSR_NEVER(a_emit_free, (cmd.prefix_emit || cmd.lit_emit || cmd.copy_write) && !sts.out_free, "output register overwritten")

endmodule

>>> rtl/core/lzss_ring_decompressor.sv
// Top level of the LZSS ring decompressor.
// Depends on lzssr_pkg, lzssr_ctrl and lzssr_dp.

// LZSS decoder with a 4096-byte history ring. Compressed bytes enter one per
// transfer on the input channel; decompressed bytes leave one per transfer on
// the output channel, with last_of_run set on the final byte caused by an input
// byte. A start_of_file mark on an input byte restores the initial state (ring
// reads as spaces, write position 0xFEE, flag byte needed) and loads the raw
// prefix count from raw_prefix_len; values above four act as four, and a write
// to the register takes effect at the next start_of_file.
// Raw prefix bytes, literals, flag bytes and the low byte of a reference are
// each handled as the byte is taken. The high byte of a reference starts a
// copy: the ring is a single memory that is read at the source in the copy
// read state and written at the write position, with the byte handed to the
// output register, in the copy write state, which waits for a free output
// register. Only bytes written since the last start_of_file are tracked by a
// fill count, so there is no clearing pass after reset or at a new file. The
// output register frees in the cycle its byte is taken, so the next input
// byte can be taken in that same cycle; while a byte waits on the output the
// input is held, and any stall on the output holds the copy in progress.
module lzss_ring_decompressor (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [2:0]           cfg_wr_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  lzssr_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output lzssr_pkg::out_item_t out_data
);

	// Commands tell the datapath what to do with the current transfer or copy step.
	lzssr_pkg::cmd_t cmd;
	// Status is the decoder state as seen by the byte at the input.
	lzssr_pkg::sts_t sts;

	lzssr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lzssr_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule
